### rtl/tpp_pkg.sv
// Shared types and constants for the tracker pattern packer.
`timescale 1ns / 1ps
package tpp_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int MAX_B    = 7;

	typedef enum logic [1:0] {
		REQ_CELL  = 2'd0,
		REQ_EOR   = 2'd1,
		REQ_START = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	localparam logic [7:0] EMPTY8    = 8'd255;
	localparam logic [8:0] EMPTY_VOL = 9'd256;
	localparam logic [7:0] MARK_BIT  = 8'd128;
	localparam logic [6:0] NOTE_OFF  = 7'd120;
	localparam logic [6:0] NOTE_CUT  = 7'd121;
	localparam logic [7:0] OFF_CODE  = 8'd255;
	localparam logic [7:0] CUT_CODE  = 8'd254;

	localparam logic [7:0] W_NOTE = 8'h01;
	localparam logic [7:0] W_INST = 8'h02;
	localparam logic [7:0] W_VOL  = 8'h04;
	localparam logic [7:0] W_CMD  = 8'h08;
	localparam logic [7:0] R_NOTE = 8'h10;
	localparam logic [7:0] R_INST = 8'h20;
	localparam logic [7:0] R_VOL  = 8'h40;
	localparam logic [7:0] R_CMD  = 8'h80;

	// per-channel cache word
	typedef struct packed {
		logic [7:0] note;
		logic [7:0] inst;
		logic [8:0] vol;
		logic [7:0] cmd;
		logic [7:0] par;
		logic [7:0] mask;
	} entry_t;

	localparam entry_t ENTRY_RST = '{
		note: EMPTY8, inst: EMPTY8, vol: EMPTY_VOL, cmd: EMPTY8, par: 8'd0, mask: 8'd0
	};

	// bytes produced by one item, first byte in slot 0
	typedef struct packed {
		logic [MAX_B-1:0][7:0] bytes;
		logic [2:0]            cnt;
	} burst_t;

endpackage

### rtl/tpp_serializer.sv
// Output stage: holds one item's bytes and shifts them out one per handshake.
`timescale 1ns / 1ps
module tpp_serializer import tpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  burst_t     burst,
	output logic       rdy,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic       m_tlast
);

	logic [MAX_B-1:0][7:0] bytes_q;
	logic [2:0]            cnt_q;

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tlast  = (cnt_q == 3'd1);
	assign m_tdata  = bytes_q[0];
	assign rdy      = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (m_tvalid && m_tready) begin
			bytes_q <= {8'd0, bytes_q[MAX_B-1:1]};
		end
	end

endmodule

### rtl/tracker_pattern_packer.sv
// Top level: per-channel cache memory, read-modify-write stage and output stage.
//
//  channel | dir | tdata                          | tuser         | tlast
//  s_*     | in  | cell fields, 56 bits (49 used) | req_type [1:0]| -
//  m_*     | out | byte_out [7:0]                 | -             | last byte of item
//
// An item is taken every cycle while the output stage can accept its bytes;
// a cell puts out 1 to 7 bytes, an end of row 1.
// The cache memory is read at accept and written back when the item moves on;
// the first byte leaves from the output stage register after the update stage.
// Reset and a start item clear 64 valid bits at once; no clearing pass.
// Output stalls back up through the update stage to s_tready.
`timescale 1ns / 1ps
module tracker_pattern_packer import tpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [5:0] channel, [12:6] note, [13] note_empty, [21:14] instrument,
	// [22] instrument_empty, [30:23] volume, [31] volume_empty,
	// [39:32] command, [40] command_empty, [48:41] parameter_req, [55:49] zero
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] byte_out
	output logic        m_tlast
);

	entry_t mem [CHANNELS];
	entry_t rd_q;

	logic                s1_v;
	req_t                s1_type;
	logic [CH_W-1:0]     s1_ch;
	logic [6:0]          s1_note;
	logic                s1_ne;
	logic [7:0]          s1_inst;
	logic                s1_ie;
	logic [7:0]          s1_vol;
	logic                s1_ve;
	logic [7:0]          s1_cmd;
	logic                s1_ce;
	logic [7:0]          s1_par;

	logic [CHANNELS-1:0] valid_q;
	logic                fwd_v_q;
	logic [CH_W-1:0]     fwd_ch_q;
	entry_t              fwd_q;

	logic   in_acc, s1_adv, ser_rdy, wr_en, clr, is_cell;
	entry_t cur, nxt;
	burst_t burst;
	logic [7:0] flags, cmd_code;
	logic [MAX_B-1:0][7:0] cand;
	logic [MAX_B-1:0]      en;
	logic [2:0]            k;

	assign in_acc   = s_tvalid && s_tready;
	assign s1_adv   = s1_v && (burst.cnt == 3'd0 || ser_rdy);
	assign s_tready = !s1_v || s1_adv;

	// cache lookup: cleared entries read as reset, last write forwarded
	always_comb begin
		if (!valid_q[s1_ch]) begin
			cur = ENTRY_RST;
		end else if (fwd_v_q && fwd_ch_q == s1_ch) begin
			cur = fwd_q;
		end else begin
			cur = rd_q;
		end
	end

	always_comb begin
		is_cell = (s1_type == REQ_CELL) && ({1'b0, s1_ch} < 7'(CHANNELS)) &&
			!(s1_ne && s1_ie && s1_ve && s1_ce && s1_par == 8'd0);
		flags    = 8'd0;
		nxt      = cur;
		cmd_code = s1_ce ? EMPTY8 : s1_cmd;
		if (!s1_ne) begin
			if ({1'b0, s1_note} != cur.note) begin
				flags    = flags | W_NOTE;
				nxt.note = {1'b0, s1_note};
			end else begin
				flags = flags | R_NOTE;
			end
		end
		if (!s1_ie) begin
			if (s1_inst != cur.inst) begin
				flags    = flags | W_INST;
				nxt.inst = s1_inst;
			end else begin
				flags = flags | R_INST;
			end
		end
		if (!s1_ve) begin
			if ({1'b0, s1_vol} != cur.vol) begin
				flags   = flags | W_VOL;
				nxt.vol = {1'b0, s1_vol};
			end else begin
				flags = flags | R_VOL;
			end
		end
		if (!s1_ce || s1_par != 8'd0) begin
			if (cmd_code != cur.cmd || s1_par != cur.par) begin
				flags   = flags | W_CMD;
				nxt.cmd = cmd_code;
				nxt.par = s1_par;
			end else begin
				flags = flags | R_CMD;
			end
		end
		nxt.mask = flags;

		// candidate bytes in stream order
		if (flags != cur.mask) begin
			cand[0] = ({2'b00, s1_ch} + 8'd1) | MARK_BIT;
		end else begin
			cand[0] = {2'b00, s1_ch} + 8'd1;
		end
		en[0]   = 1'b1;
		cand[1] = flags;
		en[1]   = (flags != cur.mask);
		if (s1_note == NOTE_OFF) begin
			cand[2] = OFF_CODE;
		end else if (s1_note == NOTE_CUT) begin
			cand[2] = CUT_CODE;
		end else begin
			cand[2] = {1'b0, s1_note};
		end
		en[2]   = (flags & W_NOTE) != 8'd0;
		cand[3] = s1_inst + 8'd1;
		en[3]   = (flags & W_INST) != 8'd0;
		cand[4] = s1_vol;
		en[4]   = (flags & W_VOL) != 8'd0;
		cand[5] = s1_ce ? 8'd0 : s1_cmd + 8'd1;
		en[5]   = (flags & W_CMD) != 8'd0;
		cand[6] = s1_par;
		en[6]   = (flags & W_CMD) != 8'd0;

		burst.bytes = '0;
		burst.cnt   = 3'd0;
		k           = 3'd0;
		case (s1_type)
			REQ_EOR: begin
				burst.cnt = 3'd1;
			end
			REQ_CELL: begin
				if (is_cell) begin
					for (int i = 0; i < MAX_B; i++) begin
						if (en[i]) begin
							burst.bytes[k] = cand[i];
							k = k + 3'd1;
						end
					end
					burst.cnt = k;
				end
			end
			default: begin
				burst.cnt = 3'd0;
			end
		endcase
	end

	assign wr_en = s1_adv && is_cell;
	assign clr   = s1_adv && (s1_type == REQ_START);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= mem[s_tdata[CH_W-1:0]];
		end
		if (wr_en) begin
			mem[s1_ch] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			valid_q <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_v <= 1'b1;
			end else if (s1_adv) begin
				s1_v <= 1'b0;
			end
			if (clr) begin
				valid_q <= '0;
				fwd_v_q <= 1'b0;
			end else if (wr_en) begin
				valid_q[s1_ch] <= 1'b1;
				fwd_v_q        <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_type <= req_t'(s_tuser);
			s1_ch   <= s_tdata[5:0];
			s1_note <= s_tdata[12:6];
			s1_ne   <= s_tdata[13];
			s1_inst <= s_tdata[21:14];
			s1_ie   <= s_tdata[22];
			s1_vol  <= s_tdata[30:23];
			s1_ve   <= s_tdata[31];
			s1_cmd  <= s_tdata[39:32];
			s1_ce   <= s_tdata[40];
			s1_par  <= s_tdata[48:41];
		end
		if (wr_en) begin
			fwd_ch_q <= s1_ch;
			fwd_q    <= nxt;
		end
	end

	tpp_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_adv && burst.cnt != 3'd0),
		.burst    (burst),
		.rdy      (ser_rdy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/tpp_checker.sv
// Port checker for the tracker pattern packer, bound to the top level.
`timescale 1ns / 1ps
module tpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// high when the next output byte opens a new item
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_rst_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |->
			(m_tdata == 8'd0 && m_tlast) ||
			(m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= 7'd64))
		else $error("item does not open with a marker or row end");

	a_mask_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q && m_tdata[7] |-> !m_tlast)
		else $error("marker with mask flag ends the item");

endmodule

bind tracker_pattern_packer tpp_checker u_tpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### test/tb_tracker_pattern_packer.sv
// Self-checking testbench for the tracker pattern packer: cache prediction and byte stream check.
`timescale 1ns / 1ps
module tb_tracker_pattern_packer;
	import tpp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 85;
	localparam int TAIL_CYCLES = 20;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [6:0] pad;
		logic [7:0] par;
		logic       cmd_empty;
		logic [7:0] cmd;
		logic       vol_empty;
		logic [7:0] vol;
		logic       inst_empty;
		logic [7:0] inst;
		logic       note_empty;
		logic [6:0] note;
		logic [5:0] ch;
	} cell_t;

	typedef struct {
		bit [7:0] data;
		bit       last;
	} packed_byte_t;

	class pattern_scoreboard;
		bit [7:0] note_c[CHANNELS];
		bit [7:0] inst_c[CHANNELS];
		bit [8:0] vol_c[CHANNELS];
		bit [7:0] cmd_c[CHANNELS];
		bit [7:0] par_c[CHANNELS];
		bit [7:0] mask_c[CHANNELS];
		packed_byte_t stream_q[$];
		int mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			for (int c = 0; c < CHANNELS; c++) begin
				note_c[c] = EMPTY8;
				inst_c[c] = EMPTY8;
				vol_c[c]  = EMPTY_VOL;
				cmd_c[c]  = EMPTY8;
				par_c[c]  = 8'd0;
				mask_c[c] = 8'd0;
			end
		endfunction

		// work out the bytes an accepted item must produce
		function void note_item(req_t req, cell_t c);
			bit [7:0] flags;
			bit [7:0] cmd_code;
			bit [7:0] chb;
			bit [7:0] seq[$];
			int ch;
			ch = c.ch;
			flags = 8'd0;
			case (req)
				REQ_START: clear();
				REQ_EOR: stream_q.insert(stream_q.size(), '{8'd0, 1'b1});
				REQ_CELL: begin
					if (ch >= CHANNELS)
						return;
					if (c.note_empty && c.inst_empty && c.vol_empty && c.cmd_empty
							&& c.par == 8'd0)
						return;
					if (!c.note_empty) begin
						if ({1'b0, c.note} != note_c[ch]) begin
							flags |= W_NOTE;
							note_c[ch] = {1'b0, c.note};
						end else
							flags |= R_NOTE;
					end
					if (!c.inst_empty) begin
						if (c.inst != inst_c[ch]) begin
							flags |= W_INST;
							inst_c[ch] = c.inst;
						end else
							flags |= R_INST;
					end
					if (!c.vol_empty) begin
						if ({1'b0, c.vol} != vol_c[ch]) begin
							flags |= W_VOL;
							vol_c[ch] = {1'b0, c.vol};
						end else
							flags |= R_VOL;
					end
					// an empty command still counts when a parameter is given
					cmd_code = c.cmd_empty ? EMPTY8 : c.cmd;
					if (!c.cmd_empty || c.par != 8'd0) begin
						if (cmd_code != cmd_c[ch] || c.par != par_c[ch]) begin
							flags |= W_CMD;
							cmd_c[ch] = cmd_code;
							par_c[ch] = c.par;
						end else
							flags |= R_CMD;
					end
					chb = 8'(ch) + 8'd1;
					if (flags != mask_c[ch]) begin
						seq.insert(seq.size(), chb | MARK_BIT);
						seq.insert(seq.size(), flags);
						mask_c[ch] = flags;
					end else
						seq.insert(seq.size(), chb);
					if (flags & W_NOTE) begin
						if (c.note == NOTE_OFF)
							seq.insert(seq.size(), OFF_CODE);
						else if (c.note == NOTE_CUT)
							seq.insert(seq.size(), CUT_CODE);
						else
							seq.insert(seq.size(), {1'b0, c.note});
					end
					if (flags & W_INST)
						seq.insert(seq.size(), c.inst + 8'd1);
					if (flags & W_VOL)
						seq.insert(seq.size(), c.vol);
					if (flags & W_CMD) begin
						seq.insert(seq.size(), c.cmd_empty ? 8'd0 : c.cmd + 8'd1);
						seq.insert(seq.size(), c.par);
					end
					foreach (seq[i])
						stream_q.insert(stream_q.size(), '{seq[i], i == seq.size() - 1});
				end
				default: ;
			endcase
		endfunction

		function void check_byte(bit [7:0] data, bit last);
			packed_byte_t e;
			if (stream_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte: expected none, got %02h last %0b",
					$time, data, last);
				return;
			end
			e = stream_q.pop_front();
			if (e.data != data || e.last != last) begin
				mismatches++;
				$display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
					$time, e.data, e.last, data, last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = REQ_CELL;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	pattern_scoreboard sb = new();

	int send_idle = 0;
	int recv_stall = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	tracker_pattern_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// both handshakes sampled at the edge; input side noted first
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(req_t'(s_tuser), cell_t'(s_tdata));
			if (m_tvalid && m_tready)
				sb.check_byte(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic cell_t mk_cell(int ch, int note, bit ne, int inst, bit ie,
			int vol, bit ve, int cmd, bit ce, int par);
		cell_t c;
		c.pad = '0;
		c.ch = 6'(ch);
		c.note = 7'(note);
		c.note_empty = ne;
		c.inst = 8'(inst);
		c.inst_empty = ie;
		c.vol = 8'(vol);
		c.vol_empty = ve;
		c.cmd = 8'(cmd);
		c.cmd_empty = ce;
		c.par = 8'(par);
		return c;
	endfunction

	// small pool most of the time so the caches get hit
	function automatic bit [7:0] pick8();
		return ($urandom_range(99) < 60) ? 8'($urandom_range(0, 3)) : 8'($urandom());
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		int r;
		c.pad = '0;
		c.ch = ($urandom_range(99) < 80) ? 6'($urandom_range(0, 7)) : 6'($urandom());
		r = $urandom_range(99);
		if (r < 10)
			c.note = 7'(NOTE_OFF + $urandom_range(0, 1));
		else if (r < 15)
			c.note = 7'($urandom_range(122, 127));
		else if (r < 60)
			c.note = 7'($urandom_range(0, 3));
		else
			c.note = 7'($urandom_range(0, 119));
		c.inst = pick8();
		c.vol = pick8();
		c.cmd = pick8();
		c.par = ($urandom_range(99) < 40) ? 8'd0 : pick8();
		c.note_empty = ($urandom_range(99) < 30);
		c.inst_empty = ($urandom_range(99) < 30);
		c.vol_empty = ($urandom_range(99) < 30);
		c.cmd_empty = ($urandom_range(99) < 30);
		if ($urandom_range(99) < 5) begin
			c.note_empty = 1'b1;
			c.inst_empty = 1'b1;
			c.vol_empty = 1'b1;
			c.cmd_empty = 1'b1;
			c.par = 8'd0;
		end
		return c;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(req_t req, cell_t c);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(output bit counted);
		cell_t c;
		int r;
		c = rand_cell();
		r = $urandom_range(99);
		counted = 1'b1;
		if (r < 78) begin
			send_item(REQ_CELL, c);
			counted = !(c.note_empty && c.inst_empty && c.vol_empty && c.cmd_empty
				&& c.par == 8'd0);
		end else if (r < 94)
			send_item(REQ_EOR, c);
		else if (r < 97) begin
			send_item(REQ_RSVD, c);
			counted = 1'b0;
		end else
			send_item(REQ_START, c);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.stream_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		bit counted;
		int n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(REQ_START, mk_cell(0, 0, 1, 0, 1, 0, 1, 0, 1, 0));
		// all fields written, then reused with a new mask, then reused with the same mask
		send_item(REQ_CELL, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(REQ_CELL, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(REQ_CELL, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(REQ_CELL, mk_cell(63, 119, 0, 254, 0, 255, 0, 254, 0, 255));
		send_item(REQ_CELL, mk_cell(63, NOTE_OFF, 0, 254, 0, 255, 0, 254, 0, 255));
		send_item(REQ_CELL, mk_cell(63, NOTE_CUT, 0, 254, 0, 255, 0, 254, 0, 255));
		// note above the cut code goes out unchanged
		send_item(REQ_CELL, mk_cell(5, 127, 0, 0, 1, 0, 1, 0, 1, 0));
		// instrument and command 255 hit the empty code in the cache
		send_item(REQ_CELL, mk_cell(6, 0, 1, 255, 0, 0, 1, 0, 1, 0));
		send_item(REQ_CELL, mk_cell(7, 0, 1, 0, 1, 0, 1, 255, 0, 0));
		// empty command with a parameter
		send_item(REQ_CELL, mk_cell(8, 0, 1, 0, 1, 0, 1, 0, 1, 8'h40));
		send_item(REQ_CELL, mk_cell(8, 0, 1, 0, 1, 0, 1, 0, 1, 8'h40));
		send_item(REQ_CELL, mk_cell(9, 127, 1, 255, 1, 255, 1, 255, 1, 0));
		send_item(REQ_EOR, mk_cell(63, 127, 1, 255, 1, 255, 1, 255, 1, 255));
		send_item(REQ_RSVD, mk_cell(3, 1, 0, 1, 0, 1, 0, 1, 0, 1));
		send_item(REQ_CELL, mk_cell(10, 0, 1, 0, 1, 255, 0, 0, 1, 0));
		send_item(REQ_CELL, mk_cell(10, 0, 1, 0, 1, 128, 0, 0, 1, 0));
		send_item(REQ_CELL, mk_cell(11, 85, 0, 170, 0, 85, 0, 170, 0, 85));
		send_item(REQ_CELL, mk_cell(42, 42, 0, 85, 0, 170, 0, 85, 0, 170));
		send_item(REQ_START, mk_cell(0, 0, 1, 0, 1, 0, 1, 0, 1, 0));
		send_item(REQ_CELL, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(REQ_CELL, mk_cell(63, 119, 0, 254, 0, 255, 0, 254, 0, 255));
		send_item(REQ_EOR, mk_cell(0, 0, 1, 0, 1, 0, 1, 0, 1, 0));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 46; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 46; end
				default: begin send_idle = 8; recv_stall = 8; end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				// long output hold-off while the sender keeps pushing
				if (phase == 0 && n == 40)
					hold_seq++;
				send_random(counted);
				if (counted)
					n++;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.stream_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
